FILE: design/sfsu_pkg.sv
// Shared types and constants for the starfield star update unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfsu_pkg;

   // Screen size defaults
   localparam int unsigned DefScreenWidth  = 160;
   localparam int unsigned DefScreenHeight = 80;

   // Hash seeds: b and c words of the final mix
   localparam logic [31:0] HashSeedB = 32'h7283_7482;
   localparam logic [31:0] HashSeedC = 32'hdead_beef;

   // Depth given to a respawned star
   localparam logic signed [16:0] RespawnDepth = 17'sh07fff;

   // Pixel code for a star that is off screen
   localparam logic [14:0] PixelOffScreen = 15'h7fff;

   // Status of an iterative arithmetic unit towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

FILE: design/starfield_star_update_unit.sv
// Starfield star update unit. One star is taken per transaction and one result
// transaction is returned for it. A respawned star takes longer than one that keeps
// flying, the extra time being two passes of the six-round hash unit (one round per
// cycle, plus a hand-over of each hash word). The bulk of the time is two projections
// through the shared divider, which yields two quotient bits per cycle. A new star
// is accepted only while the sequencer is idle, which it becomes as the result is
// loaded; a finished result waits in the output register and the next star may be
// accepted meanwhile, but a further result stalls the sequencer until that register
// is free. The respawn counter resets to 0.
// Depends on sfsu_pkg, sfsu_hash and sfsu_div.
`default_nettype none

module starfield_star_update_unit import sfsu_pkg::*; #(
   parameter int unsigned SCREEN_WIDTH  = DefScreenWidth,
   parameter int unsigned SCREEN_HEIGHT = DefScreenHeight
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_star_x,
   input  wire logic signed [15:0] req_star_y,
   input  wire logic signed [15:0] req_star_z,
   input  wire logic signed [15:0] req_star_pixel,
   input  wire logic [11:0]        req_step_delta,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_new_x,
   output logic signed [15:0]      rsp_new_y,
   output logic signed [16:0]      rsp_new_z,
   output logic signed [14:0]      rsp_new_pixel,
   output logic                    rsp_respawned
);

   localparam logic signed [23:0] HalfWidth  = 24'(SCREEN_WIDTH / 2);
   localparam logic signed [23:0] HalfHeight = 24'(SCREEN_HEIGHT / 2);
   localparam logic signed [23:0] WidthS     = 24'(SCREEN_WIDTH);
   localparam logic signed [23:0] HeightS    = 24'(SCREEN_HEIGHT);
   localparam logic [20:0]        WidthU     = 21'(SCREEN_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_HASH_X,
      ST_HASH_Y,
      ST_DIV_X,
      ST_DIV_Y,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic signed [15:0]     x_ff, y_ff;
   logic signed [16:0]     z_ff;
   logic                   resp_ff;
   logic signed [23:0]     px_ff, py_ff;
   logic [31:0]            rng_counter_ff;
   logic                   rsp_valid_ff;
   logic signed [15:0]     out_x_ff, out_y_ff;
   logic signed [16:0]     out_z_ff;
   logic [14:0]            out_pix_ff;
   logic                   out_resp_ff;

   // Unit interfaces
   unit_status_type        hash_status, div_status;
   logic                   hash_start, div_start;
   logic [31:0]            hash_seed, hash_result;
   logic [31:0]            div_dividend, div_quotient;
   logic signed [15:0]     div_coord;
   logic [15:0]            coord_mag;

   // Input decode and projection
   logic signed [16:0]     z_step;
   logic                   need_respawn;
   logic                   proj_neg;
   logic [32:0]            mag_up;
   logic [22:0]            proj_mag;
   logic signed [22:0]     proj_val;
   logic signed [23:0]     proj_x, proj_y;
   logic                   off_screen;
   logic [20:0]            pix_full;
   logic                   out_free;

   sfsu_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .seed   (hash_seed),
      .status (hash_status),
      .result (hash_result)
   );

   sfsu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (z_ff[14:0]),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Depth step done wide, and the respawn test
   always_comb begin
      z_step       = 17'(req_star_z) - 17'(signed'({1'b0, req_step_delta}));
      need_respawn = (z_step <= 17'sd0) || req_star_pixel[15];
   end

   // Unit launch control
   always_comb begin
      hash_start = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_LAUNCH: begin
            hash_start = resp_ff;
            div_start  = !resp_ff;
         end
         ST_HASH_X: hash_start = hash_status.done;
         ST_HASH_Y: div_start  = hash_status.done;
         ST_DIV_X:  div_start  = div_status.done;
         default: begin
            hash_start = 1'b0;
            div_start  = 1'b0;
         end
      endcase
      hash_seed    = (state_ff == ST_HASH_X) ? rng_counter_ff + 32'd1 : rng_counter_ff;
      div_coord    = (state_ff == ST_DIV_X) ? y_ff : x_ff;
      coord_mag    = div_coord[15] ? 16'(-div_coord) : 16'(div_coord);
      div_dividend = {coord_mag, 16'h0000};
   end

   // Truncated quotient, then floor division by 1024
   always_comb begin
      proj_neg = (state_ff == ST_DIV_Y) ? y_ff[15] : x_ff[15];
      mag_up   = {1'b0, div_quotient} + 33'd1023;
      proj_mag = proj_neg ? mag_up[32:10] : {1'b0, div_quotient[31:10]};
      proj_val = proj_neg ? -signed'(proj_mag) : signed'(proj_mag);
      proj_x   = 24'(proj_val) + HalfWidth;
      proj_y   = 24'(proj_val) + HalfHeight;
   end

   // Screen clip and linear pixel index
   always_comb begin
      off_screen = (px_ff < 24'sd0) || (px_ff >= WidthS) ||
                   (py_ff < 24'sd0) || (py_ff >= HeightS);
      pix_full   = {10'd0, px_ff[10:0]} + {11'd0, py_ff[9:0]} * WidthU;
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rng_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // Drained on acceptance; the finish state reloads it instead
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_star_x;
                  y_ff     <= req_star_y;
                  z_ff     <= need_respawn ? RespawnDepth : z_step;
                  resp_ff  <= need_respawn;
                  state_ff <= ST_LAUNCH;
               end
            end
            ST_LAUNCH: begin
               state_ff <= resp_ff ? ST_HASH_X : ST_DIV_X;
            end
            ST_HASH_X: begin
               if (hash_status.done) begin
                  x_ff           <= hash_result[15:0];
                  rng_counter_ff <= rng_counter_ff + 32'd1;
                  state_ff       <= ST_HASH_Y;
               end
            end
            ST_HASH_Y: begin
               if (hash_status.done) begin
                  y_ff           <= hash_result[15:0];
                  rng_counter_ff <= rng_counter_ff + 32'd1;
                  state_ff       <= ST_DIV_X;
               end
            end
            ST_DIV_X: begin
               if (div_status.done) begin
                  px_ff    <= proj_x;
                  state_ff <= ST_DIV_Y;
               end
            end
            ST_DIV_Y: begin
               if (div_status.done) begin
                  py_ff    <= proj_y;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  out_x_ff     <= x_ff;
                  out_y_ff     <= y_ff;
                  out_z_ff     <= z_ff;
                  out_pix_ff   <= off_screen ? PixelOffScreen : pix_full[14:0];
                  out_resp_ff  <= resp_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_x     = out_x_ff;
   assign rsp_new_y     = out_y_ff;
   assign rsp_new_z     = out_z_ff;
   assign rsp_new_pixel = out_pix_ff;
   assign rsp_respawned = out_resp_ff;

   // Each respawn draws two hashes, so the counter is even between stars
   a_counter_even: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rng_counter_ff[0])
      else $error("respawn counter odd while idle");

   // The hash unit and the divider never run together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(hash_status.busy && div_status.busy))
      else $error("hash and divider busy together");

   // A respawned star always carries the respawn depth
   a_respawn_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_resp_ff) |-> (out_z_ff == RespawnDepth))
      else $error("respawned star with wrong depth");

   // A star that keeps flying has positive depth
   a_live_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_resp_ff) |-> (!out_z_ff[16] && (out_z_ff != 17'sd0)))
      else $error("live star with non-positive depth");

   // The divider is only launched with a positive divisor
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (z_ff[14:0] != 15'd0))
      else $error("divider launched with zero depth");

endmodule

`default_nettype wire

FILE: design/sfsu_hash.sv
// Iterative final-mix hash: one of six mix rounds per cycle.
// Depends on sfsu_pkg for the seed constants and status struct.
`default_nettype none

module sfsu_hash import sfsu_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [31:0]         seed,
   output unit_status_type          status,
   output logic [31:0]              result
);

   // Rotation amount of each round
   function automatic logic [4:0] round_rot(input logic [2:0] rnd);
      logic [4:0] k;
      begin
         case (rnd)
            3'd0:    k = 5'd4;
            3'd1:    k = 5'd6;
            3'd2:    k = 5'd8;
            3'd3:    k = 5'd16;
            3'd4:    k = 5'd19;
            3'd5:    k = 5'd4;
            default: k = 5'd4;
         endcase
         return k;
      end
   endfunction

   // Working words rotate roles each round: x -= y; x ^= rotl(y); y += z
   logic [31:0] x_ff, y_ff, z_ff;
   logic [31:0] x_in, y_in, z_in;
   logic [2:0]  round_ff, round_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] x_mix, y_mix, y_rot;
   logic [4:0]  rot_k;
   logic [5:0]  rot_r;

   // One mix round
   always_comb begin
      rot_k = round_rot(round_ff);
      rot_r = 6'd32 - {1'b0, rot_k};
      y_rot = (y_ff << rot_k) | (y_ff >> rot_r);
      x_mix = (x_ff - y_ff) ^ y_rot;
      y_mix = y_ff + z_ff;
   end

   // Round sequencing
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         x_in     = seed;
         y_in     = HashSeedC;
         z_in     = HashSeedB;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         x_in     = z_ff;
         y_in     = x_mix;
         z_in     = y_mix;
         round_in = round_ff + 3'd1;
         if (round_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // After the last round the c word sits in the y slot
   assign result      = y_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

FILE: design/sfsu_div.sv
// Restoring unsigned divider, two quotient bits per cycle, 32 by 15 bits.
// Depends on sfsu_pkg for the status struct.
`default_nettype none

module sfsu_div import sfsu_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [31:0]         dividend,
   input  wire logic [14:0]         divisor,
   output unit_status_type          status,
   output logic [31:0]              quotient
);

   logic [14:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [14:0] dvs_ff, dvs_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [15:0] part1, part2, red1, red2;
   logic        ge1, ge2;

   // Two dependent compare-subtract steps
   always_comb begin
      part1 = {rem_ff, quo_ff[31]};
      ge1   = part1 >= {1'b0, dvs_ff};
      red1  = ge1 ? part1 - {1'b0, dvs_ff} : part1;
      part2 = {red1[14:0], quo_ff[30]};
      ge2   = part2 >= {1'b0, dvs_ff};
      red2  = ge2 ? part2 - {1'b0, dvs_ff} : part2;
   end

   // Step control: dividend bits shift out as quotient bits shift in
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = red2[14:0];
         quo_in = {quo_ff[29:0], ge1, ge2};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire
